>>> src/astm_pkg.sv
// Shared types, constants and lookup functions for the ADC scan trimmed-mean filter.
// No dependencies; every other file in src imports this package.
`default_nettype none

package astm_pkg;

	localparam int SampleW = 10;
	localparam int SumW    = 13;
	localparam int SlotW   = 3;
	localparam int CountW  = 3;
	localparam int MuxW    = 4;

	localparam logic [CountW-1:0]  SAMPLES_LAST = 3'd5;
	localparam logic [SampleW-1:0] BATTERY_OFFSET_RST = 10'd3;
	localparam logic [SampleW-1:0] CHARGE_OFFSET_RST  = 10'd4;

	// configuration register indexes
	localparam logic CFG_BATTERY_OFFSET = 1'b0;
	localparam logic CFG_CHARGE_OFFSET  = 1'b1;

	// scan slots that carry an offset correction
	localparam logic [SlotW-1:0] SLOT_BATTERY = 3'd0;
	localparam logic [SlotW-1:0] SLOT_CHARGE  = 3'd2;

	typedef struct packed {
		logic [7:0] adc_high;
		logic [1:0] adc_low;
	} astm_in_t;

	typedef struct packed {
		logic               result_valid;
		logic [SlotW-1:0]   result_channel;
		logic [SampleW-1:0] result_value;
		logic [MuxW-1:0]    mux_select;
		logic               ref_is_vdd;
	} astm_out_t;

	// snapshot of the running tally after one sample, handed to the trim stage
	typedef struct packed {
		logic               done;
		logic [SlotW-1:0]   channel;
		logic [SumW-1:0]    sum;
		logic [SampleW-1:0] min_val;
		logic [SampleW-1:0] max_val;
		logic [MuxW-1:0]    mux_next;
		logic               ref_next;
	} astm_tally_t;

	function automatic logic [MuxW-1:0] mux_code(input logic [SlotW-1:0] slot);
		logic [MuxW-1:0] code;
		case (slot)
			3'd0: code = 4'h0;
			3'd1: code = 4'h2;
			3'd2: code = 4'h3;
			3'd3: code = 4'h4;
			3'd4: code = 4'h6;
			3'd5: code = 4'h7;
			3'd6: code = 4'h8;
			3'd7: code = 4'hb;
			default: code = 4'h0;
		endcase
		return code;
	endfunction

	// reference to use once the given slot has finished: VDD after slots 3..5
	function automatic logic ref_after(input logic [SlotW-1:0] slot);
		logic vdd;
		case (slot)
			3'd3, 3'd4, 3'd5: vdd = 1'b1;
			default: vdd = 1'b0;
		endcase
		return vdd;
	endfunction

endpackage

`default_nettype wire

>>> src/astm_tally.sv
// Running tally of the scan: slot, sample count, min, max, sum and reference state.
// Depends on astm_pkg.
`default_nettype none

module astm_tally
	import astm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire astm_in_t    conv,
	output astm_tally_t      tally
);

	logic [SlotW-1:0]   slot_q;
	logic [CountW-1:0]  count_q;
	logic [SampleW-1:0] min_q;
	logic [SampleW-1:0] max_q;
	logic [SumW-1:0]    sum_q;
	logic               ref_q;

	logic [SampleW-1:0] sample;
	logic               first;
	logic               last;
	logic               below_min;
	logic [SampleW-1:0] min_nxt;
	logic [SampleW-1:0] max_nxt;
	logic [SumW-1:0]    sum_nxt;
	logic [CountW-1:0]  count_nxt;
	logic [SlotW-1:0]   slot_nxt;
	logic               ref_nxt;

	always_comb begin
		sample    = {conv.adc_high, conv.adc_low};
		first     = (count_q == '0);
		last      = (count_q >= SAMPLES_LAST);
		below_min = (sample < min_q);
		// first sample of a slot seeds min and max; later ones only widen them
		if (first) begin
			min_nxt = sample;
			max_nxt = sample;
		end else if (below_min) begin
			min_nxt = sample;
			max_nxt = max_q;
		end else if (sample > max_q) begin
			min_nxt = min_q;
			max_nxt = sample;
		end else begin
			min_nxt = min_q;
			max_nxt = max_q;
		end
		sum_nxt   = (first ? '0 : sum_q) + SumW'(sample);
		count_nxt = last ? '0 : count_q + CountW'(1);
		slot_nxt  = last ? slot_q + SlotW'(1) : slot_q;
		ref_nxt   = last ? ref_after(slot_q) : ref_q;

		tally.done     = last;
		tally.channel  = slot_q;
		tally.sum      = sum_nxt;
		tally.min_val  = min_nxt;
		tally.max_val  = max_nxt;
		tally.mux_next = mux_code(slot_nxt);
		tally.ref_next = ref_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			ref_q   <= 1'b0;
		end else if (step) begin
			slot_q  <= slot_nxt;
			count_q <= count_nxt;
			sum_q   <= sum_nxt;
			ref_q   <= ref_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			min_q <= min_nxt;
			max_q <= max_nxt;
		end
	end

endmodule

`default_nettype wire

>>> src/astm_trim.sv
// Trim stage: drop min and max, average the other four, apply the slot offset.
// Depends on astm_pkg.
`default_nettype none

module astm_trim
	import astm_pkg::*;
(
	input  wire astm_tally_t        tally,
	input  wire logic [SampleW-1:0] battery_offset,
	input  wire logic [SampleW-1:0] charge_offset,
	output astm_out_t               rpt
);

	logic [SumW-1:0]    trimmed;
	logic [SampleW-1:0] avg;
	logic [SampleW-1:0] corrected;

	always_comb begin
		trimmed = tally.sum - SumW'(tally.max_val) - SumW'(tally.min_val);
		avg     = trimmed[SampleW+1:2];
		// subtract the offset only when it does not underflow
		if (tally.channel == SLOT_BATTERY && avg >= battery_offset) begin
			corrected = avg - battery_offset;
		end else if (tally.channel == SLOT_CHARGE && avg >= charge_offset) begin
			corrected = avg - charge_offset;
		end else begin
			corrected = avg;
		end

		rpt.result_valid   = tally.done;
		rpt.result_channel = tally.done ? tally.channel : '0;
		rpt.result_value   = tally.done ? corrected : '0;
		rpt.mux_select     = tally.mux_next;
		rpt.ref_is_vdd     = tally.ref_next;
	end

endmodule

`default_nettype wire

>>> src/adc_scan_trimmed_mean.sv
// Top level of the ADC scan trimmed-mean filter: beat registers, config registers, assertions.
// Depends on astm_pkg, astm_tally and astm_trim.
`default_nettype none

// Each conv beat carries one finished 10-bit conversion (adc_high:adc_low). The block walks
// eight scan slots, six samples per slot; on the sixth sample of a slot it drops the
// smallest and largest sample, averages the remaining four and, for slot 0 and slot 2,
// subtracts battery_offset or charge_offset when the average is at least that offset.
// Every conv beat yields exactly one rpt beat, which also carries the mux code and the
// reference for the next conversion; result_valid marks the beats that close a slot.
// Throughput is one beat per clock while rpt_stall allows; each beat passes the input register,
// then the result register, with the min/max/sum update of the running tally in between. The
// configuration port is always ready; write it only while no beat is in flight.
module adc_scan_trimmed_mean
	import astm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               conv_valid,
	output logic                    conv_stall,
	input  wire astm_in_t           conv,
	output logic                    rpt_valid,
	input  wire logic               rpt_stall,
	output astm_out_t               rpt,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [SampleW-1:0] cfg_data
);

	// input stage
	logic        conv_vld_s1;
	astm_in_t    conv_s1;

	// result stage
	logic        rpt_vld_q;
	astm_out_t   rpt_q;

	// configuration registers
	logic [SampleW-1:0] battery_offset_q;
	logic [SampleW-1:0] charge_offset_q;

	logic        advance;
	logic        step;
	astm_tally_t tally;
	astm_out_t   rpt_nxt;

	// The result register moves whenever it is empty or being drained; the input
	// register stalls only when it holds a beat that cannot move on.
	assign advance    = !rpt_vld_q || !rpt_stall;
	assign conv_stall = conv_vld_s1 && !advance;
	assign step       = conv_vld_s1 && advance;
	assign cfg_ready  = 1'b1;
	assign rpt_valid  = rpt_vld_q;
	assign rpt        = rpt_q;

	// Capture a conv beat whenever the input register is free to take one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_vld_s1 <= 1'b0;
		end else if (!conv_stall) begin
			conv_vld_s1 <= conv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!conv_stall && conv_valid) begin
			conv_s1 <= conv;
		end
	end

	// Running tally: state advances exactly once per beat that leaves the input register.
	astm_tally u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.conv   (conv_s1),
		.tally  (tally)
	);

	// Trim, average and offset correction of the closing sample.
	astm_trim u_trim (
		.tally          (tally),
		.battery_offset (battery_offset_q),
		.charge_offset  (charge_offset_q),
		.rpt            (rpt_nxt)
	);

	// Result register: hold while stalled, advance otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_vld_q <= 1'b0;
		end else if (advance) begin
			rpt_vld_q <= conv_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rpt_q <= rpt_nxt;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_offset_q <= BATTERY_OFFSET_RST;
			charge_offset_q  <= CHARGE_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BATTERY_OFFSET: battery_offset_q <= cfg_data;
				CFG_CHARGE_OFFSET:  charge_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input side stalls only while it holds a beat.
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		conv_stall |-> conv_vld_s1)
		else $error("conv stalled with an empty input register");

	// A beat that does not close a slot reports zero channel and value.
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && !rpt.result_valid) |->
		(rpt.result_channel == '0 && rpt.result_value == '0))
		else $error("result fields set without a completed average");

	// Closing a slot sets the reference: VDD exactly after slots 3, 4 and 5.
	a_ref_after_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && rpt.result_valid) |->
		(rpt.ref_is_vdd == (rpt.result_channel == 3'd3 || rpt.result_channel == 3'd4 ||
			rpt.result_channel == 3'd5)))
		else $error("reference select does not follow the finished slot");

	// A beat that closes a slot points the mux at the following slot.
	a_mux_follows_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && rpt.result_valid) |-> (rpt.mux_select == mux_code(rpt.result_channel +
			SlotW'(1))))
		else $error("mux code does not point at the next slot");

endmodule

`default_nettype wire
